### rtl/spp_pkg.sv
// Shared types and constants of the speed profile and PI corrector block.
// Holds the sequencer states, register indexes and multiplier status bundle.
// No dependencies.
package spp_pkg;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_ACCEL_MAX           = 3'd0;
    localparam cfg_index_t CFG_SPEED_MAX           = 3'd1;
    localparam cfg_index_t CFG_SLOW_DISTANCE       = 3'd2;
    localparam cfg_index_t CFG_SLOW_DISTANCE_RECIP = 3'd3;
    localparam cfg_index_t CFG_PROP_GAIN           = 3'd4;
    localparam cfg_index_t CFG_INTEG_GAIN          = 3'd5;
    localparam cfg_index_t CFG_INTEG_LIMIT         = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ACC,
        ST_STEP,
        ST_CLAMP,
        ST_MUL_R1,
        ST_MUL_R2,
        ST_RAMP,
        ST_ERR,
        ST_MUL_E,
        ST_INT,
        ST_MUL_P,
        ST_MUL_I,
        ST_OUT
    } spp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

### rtl/spp_mulq.sv
// Bit-serial Q16 multiplier: one bit of the multiplier operand per cycle.
// The product is shifted right by 16, truncated toward zero and saturated.
// Depends on spp_pkg for the status bundle.
module spp_mulq import spp_pkg::*; #(
    parameter int DW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW:0]   op_a,
    input  logic signed [DW:0]   op_b,
    output mul_status_t          status,
    output logic signed [DW-1:0] result
);

    localparam int AW = DW + 1;
    localparam int CW = $clog2(AW);
    localparam logic [CW-1:0] CNT_LAST = CW'(AW - 1);

    logic          run_reg, run_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [AW-1:0] ma_reg, ma_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic signed [DW-1:0] res_reg, res_next;

    logic [AW-1:0]   a_mag;
    logic [AW-1:0]   b_mag;
    logic [AW:0]     sum;
    logic [2*AW-1:0] prod;
    logic            ovf;
    logic [DW-1:0]   mag;
    logic [DW-1:0]   lim;
    logic [DW-1:0]   mag_sat;
    logic            busy;

    assign busy  = run_reg | fin_reg;
    assign a_mag = op_a[DW] ? (~op_a + 1'b1) : op_a;
    assign b_mag = op_b[DW] ? (~op_b + 1'b1) : op_b;
    assign sum   = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, ma_reg} : {(AW + 1){1'b0}});
    assign prod  = {acc_reg, lo_reg};
    assign ovf   = |prod[2*AW-1:DW+16];
    assign mag   = prod[DW+15:16];
    assign lim   = neg_reg ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
    assign mag_sat = (ovf || (mag > lim)) ? lim : mag;

    always_comb begin
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = fin_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ma_next   = ma_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        res_next  = res_reg;
        if (start && !busy) begin
            run_next = 1'b1;
            cnt_next = '0;
            neg_next = op_a[DW] ^ op_b[DW];
            ma_next  = a_mag;
            acc_next = '0;
            lo_next  = b_mag;
        end else if (run_reg) begin
            acc_next = sum[AW:1];
            lo_next  = {sum[0], lo_reg[AW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        if (fin_reg) begin
            res_next = neg_reg ? -$signed(mag_sat) : $signed(mag_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        ma_reg  <= ma_next;
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        res_reg <= res_next;
    end

    assign status.busy = busy;
    assign status.done = done_reg;
    assign result      = res_reg;

    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !busy) |=> run_reg)
        else $error("multiplier did not start");

    a_last_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg && cnt_reg == CNT_LAST) |=> (fin_reg && !run_reg))
        else $error("multiplier did not finish after the last bit");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!run_reg && !fin_reg))
        else $error("multiplier reported done while still working");

endmodule

### rtl/speed_profile_pi_axis_top.sv
// Top level of the linear-axis speed profile with PI speed corrector.
// Depends on spp_pkg and the bit-serial multiplier spp_mulq.
//
// Usage: one input beat per control tick carries the remaining distance, the
// pass-through speed, the measured speed, the elapsed time and an integral
// clear flag. One output beat returns the speed setpoint and the drive value.
// Configuration registers are written through cfg_wen, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce. An index beyond the list is ignored.
// A tick takes 4 multiplications without braking and 6 with the braking
// ramp, each run on the shared bit-serial multiplier; at zero distance the
// clamp step is skipped. One tick is processed at a time; s_ready is high
// only while idle, which is entered in the cycle after the result is loaded.
// The output register holds a finished beat while the receiver stalls, and
// the next tick may be accepted and computed meanwhile; it waits before
// writing its result until the register is free.
// Reset clears the setpoint and integral state and loads the register
// defaults; no clearing pass is needed.
module speed_profile_pi_axis_top import spp_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_linear_error,
    input  logic        [30:0] s_pass_speed,
    input  logic signed [31:0] s_measured_speed,
    input  logic        [15:0] s_elapsed_time,
    input  logic               s_clear_integral,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_speed_setpoint,
    output logic signed [31:0] m_drive_command,
    input  logic               cfg_wen,
    input  cfg_index_t         cfg_index,
    input  logic        [30:0] cfg_wdata
);

    localparam int W  = DATA_WIDTH;
    localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int SW = XW + 2;

    localparam logic signed [SW-1:0] HI_W  = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] LO_W  = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic signed [SW-1:0] HI_32 = {{(SW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] LO_32 = {{(SW - 31){1'b1}}, {31{1'b0}}};
    localparam logic signed [SW-1:0] ONE_Q16 = {{(SW - 17){1'b0}}, 1'b1, 16'h0000};

    function automatic logic signed [SW-1:0] ext_w(input logic signed [W-1:0] v);
        return {{(SW - W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
        if (x > HI_W) begin
            return HI_W[W-1:0];
        end
        if (x < LO_W) begin
            return LO_W[W-1:0];
        end
        return x[W-1:0];
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [W-1:0] v);
        logic signed [SW-1:0] x;
        x = ext_w(v);
        if (x > HI_32) begin
            return HI_32[31:0];
        end
        if (x < LO_32) begin
            return LO_32[31:0];
        end
        return x[31:0];
    endfunction

    function automatic logic signed [SW-1:0] ext_u31(input logic [30:0] v);
        return {{(SW - 31){1'b0}}, v};
    endfunction

    function automatic logic signed [SW-1:0] ext_s32(input logic [31:0] v);
        return {{(SW - 32){v[31]}}, v};
    endfunction

    function automatic logic signed [W:0] ext_m(input logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    spp_state_t state_reg, state_next;

    logic signed [W-1:0] amax_reg, amax_next;
    logic signed [W-1:0] vmax_reg, vmax_next;
    logic signed [W-1:0] sd_reg, sd_next;
    logic signed [W-1:0] sdr_reg, sdr_next;
    logic signed [W-1:0] kp_reg, kp_next;
    logic signed [W-1:0] ki_reg, ki_next;
    logic signed [W-1:0] ilim_reg, ilim_next;

    logic signed [W-1:0] sp_reg, sp_next;
    logic signed [W-1:0] integ_reg, integ_next;

    logic signed [W-1:0] err_reg, err_next;
    logic signed [W-1:0] pass_reg, pass_next;
    logic signed [W-1:0] meas_reg, meas_next;
    logic        [15:0]  dt_reg, dt_next;
    logic                clr_reg, clr_next;
    logic signed [W-1:0] t_reg, t_next;
    logic signed [W-1:0] cand_reg, cand_next;
    logic signed [W-1:0] e_reg, e_next;
    logic signed [W-1:0] drv_reg, drv_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_speed_setpoint_reg, m_speed_setpoint_next;
    logic signed [31:0] m_drive_command_reg, m_drive_command_next;

    logic                in_ready;
    logic                is_mul;
    logic                mul_start;
    logic                out_load;
    logic                brake;
    logic                err_pos;
    logic                err_zero;
    logic signed [W:0]   mul_a;
    logic signed [W:0]   mul_b;
    logic signed [W:0]   dt_op;
    logic signed [W-1:0] mul_res;
    mul_status_t         mul_stat;

    logic signed [W-1:0] vmax_neg;
    logic signed [W-1:0] ilim_neg;
    logic signed [W-1:0] sd_neg;
    logic signed [W-1:0] step_sat;
    logic signed [W-1:0] ramp_sat;
    logic signed [W-1:0] isum_sat;
    logic signed [W:0]   brake_span;

    assign err_zero   = (err_reg == '0);
    assign err_pos    = !err_reg[W-1] && !err_zero;
    assign vmax_neg   = -vmax_reg;
    assign ilim_neg   = -ilim_reg;
    assign sd_neg     = -sd_reg;
    assign brake      = err_pos ? (err_reg < sd_reg) : (err_reg > sd_neg);
    assign dt_op      = $signed({{(W - 15){1'b0}}, dt_reg});
    assign brake_span = ext_m(vmax_reg) - ext_m(pass_reg);
    assign step_sat   = err_pos ? sat_w(ext_w(sp_reg) + ext_w(t_reg))
                                : sat_w(ext_w(sp_reg) - ext_w(t_reg));
    assign ramp_sat   = err_pos ? sat_w(ext_w(t_reg) + ext_w(pass_reg))
                                : sat_w(ext_w(t_reg) - ext_w(pass_reg));
    assign isum_sat   = sat_w(ext_w(integ_reg) + ext_w(t_reg));

    spp_mulq #(
        .DW (W)
    ) u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .status  (mul_stat),
        .result  (mul_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL_ACC;
                end
            end
            ST_MUL_ACC: begin
                if (mul_stat.done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = err_zero ? ST_ERR : ST_CLAMP;
            end
            ST_CLAMP: begin
                state_next = brake ? ST_MUL_R1 : ST_ERR;
            end
            ST_MUL_R1: begin
                if (mul_stat.done) begin
                    state_next = ST_MUL_R2;
                end
            end
            ST_MUL_R2: begin
                if (mul_stat.done) begin
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP: begin
                state_next = ST_ERR;
            end
            ST_ERR: begin
                state_next = ST_MUL_E;
            end
            ST_MUL_E: begin
                if (mul_stat.done) begin
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                if (mul_stat.done) begin
                    state_next = ST_MUL_I;
                end
            end
            ST_MUL_I: begin
                if (mul_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        is_mul   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_MUL_ACC, ST_MUL_R1, ST_MUL_R2, ST_MUL_E, ST_MUL_P, ST_MUL_I: begin
                is_mul = 1'b1;
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        mul_start = is_mul && !mul_stat.busy && !mul_stat.done;
    end

    always_comb begin
        mul_a = ext_m(amax_reg);
        mul_b = dt_op;
        case (state_reg)
            ST_MUL_R1: begin
                mul_a = brake_span;
                mul_b = ext_m(err_reg);
            end
            ST_MUL_R2: begin
                mul_a = ext_m(t_reg);
                mul_b = ext_m(sdr_reg);
            end
            ST_MUL_E: begin
                mul_a = ext_m(e_reg);
                mul_b = dt_op;
            end
            ST_MUL_P: begin
                mul_a = ext_m(kp_reg);
                mul_b = ext_m(e_reg);
            end
            ST_MUL_I: begin
                mul_a = ext_m(ki_reg);
                mul_b = ext_m(integ_reg);
            end
            default: begin
                mul_a = ext_m(amax_reg);
                mul_b = dt_op;
            end
        endcase
    end

    always_comb begin
        amax_next  = amax_reg;
        vmax_next  = vmax_reg;
        sd_next    = sd_reg;
        sdr_next   = sdr_reg;
        kp_next    = kp_reg;
        ki_next    = ki_reg;
        ilim_next  = ilim_reg;
        sp_next    = sp_reg;
        integ_next = integ_reg;
        err_next   = err_reg;
        pass_next  = pass_reg;
        meas_next  = meas_reg;
        dt_next    = dt_reg;
        clr_next   = clr_reg;
        t_next     = t_reg;
        cand_next  = cand_reg;
        e_next     = e_reg;
        drv_next   = drv_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_speed_setpoint_next = m_speed_setpoint_reg;
        m_drive_command_next  = m_drive_command_reg;

        if (cfg_wen) begin
            case (cfg_index)
                CFG_ACCEL_MAX:           amax_next = sat_w(ext_u31(cfg_wdata));
                CFG_SPEED_MAX:           vmax_next = sat_w(ext_u31(cfg_wdata));
                CFG_SLOW_DISTANCE:       sd_next   = sat_w(ext_u31(cfg_wdata));
                CFG_SLOW_DISTANCE_RECIP: sdr_next  = sat_w(ext_u31(cfg_wdata));
                CFG_PROP_GAIN:           kp_next   = sat_w(ext_u31(cfg_wdata));
                CFG_INTEG_GAIN:          ki_next   = sat_w(ext_u31(cfg_wdata));
                CFG_INTEG_LIMIT:         ilim_next = sat_w(ext_u31(cfg_wdata));
                default:                 amax_next = amax_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next  = sat_w(ext_s32(s_linear_error));
                    pass_next = sat_w(ext_u31(s_pass_speed));
                    meas_next = sat_w(ext_s32(s_measured_speed));
                    dt_next   = s_elapsed_time;
                    clr_next  = s_clear_integral;
                end
            end
            ST_MUL_ACC, ST_MUL_R1, ST_MUL_R2, ST_MUL_E, ST_MUL_P: begin
                if (mul_stat.done) begin
                    t_next = mul_res;
                end
            end
            ST_STEP: begin
                cand_next = err_zero ? '0 : step_sat;
            end
            ST_CLAMP: begin
                if (err_pos && (cand_reg > vmax_reg)) begin
                    cand_next = vmax_reg;
                end else if (!err_pos && (cand_reg < vmax_neg)) begin
                    cand_next = vmax_neg;
                end
            end
            ST_RAMP: begin
                if (err_pos ? (ramp_sat < cand_reg) : (ramp_sat > cand_reg)) begin
                    cand_next = ramp_sat;
                end
            end
            ST_ERR: begin
                sp_next = cand_reg;
                e_next  = sat_w(ext_w(cand_reg) - ext_w(meas_reg));
                if (clr_reg) begin
                    integ_next = '0;
                end
            end
            ST_INT: begin
                if (isum_sat > ilim_reg) begin
                    integ_next = ilim_reg;
                end else if (isum_sat < ilim_neg) begin
                    integ_next = ilim_neg;
                end else begin
                    integ_next = isum_sat;
                end
            end
            ST_MUL_I: begin
                if (mul_stat.done) begin
                    drv_next = sat_w(ext_w(t_reg) + ext_w(mul_res));
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next          = 1'b1;
                    m_speed_setpoint_next = sat_32(sp_reg);
                    m_drive_command_next  = sat_32(drv_reg);
                end
            end
            default: begin
                t_next = t_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            amax_reg    <= sat_w(ONE_Q16);
            vmax_reg    <= sat_w(ONE_Q16);
            sd_reg      <= sat_w(ONE_Q16);
            sdr_reg     <= sat_w(ONE_Q16);
            kp_reg      <= sat_w(ONE_Q16);
            ki_reg      <= '0;
            ilim_reg    <= sat_w(ONE_Q16);
            sp_reg      <= '0;
            integ_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            amax_reg    <= amax_next;
            vmax_reg    <= vmax_next;
            sd_reg      <= sd_next;
            sdr_reg     <= sdr_next;
            kp_reg      <= kp_next;
            ki_reg      <= ki_next;
            ilim_reg    <= ilim_next;
            sp_reg      <= sp_next;
            integ_reg   <= integ_next;
        end
        err_reg  <= err_next;
        pass_reg <= pass_next;
        meas_reg <= meas_next;
        dt_reg   <= dt_next;
        clr_reg  <= clr_next;
        t_reg    <= t_next;
        cand_reg <= cand_next;
        e_reg    <= e_next;
        drv_reg  <= drv_next;
        m_speed_setpoint_reg <= m_speed_setpoint_next;
        m_drive_command_reg  <= m_drive_command_next;
    end

    assign s_ready          = in_ready;
    assign m_valid          = m_valid_reg;
    assign m_speed_setpoint = m_speed_setpoint_reg;
    assign m_drive_command  = m_drive_command_reg;

    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result overwrote a beat the receiver had not taken");

    a_integ_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_P) |-> (integ_reg <= ilim_reg && integ_reg >= ilim_neg))
        else $error("integral outside its limit after update");

    a_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ERR && err_zero) |-> (cand_reg == '0))
        else $error("setpoint not zero at zero distance");

    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> is_mul)
        else $error("multiplier result arrived outside a multiply step");

endmodule

### tb/speed_profile_pi_axis_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for speed_profile_pi_axis_top: a directed table, then random approach
// moves under several register settings, each beat checked against the table or a local model.
// Depends on spp_pkg and the RTL of speed_profile_pi_axis_top.
module speed_profile_pi_axis_top_tb import spp_pkg::*;;

    localparam int TICK_CYCLES = 6 * (32 + 4) + 10;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam cfg_index_t CFG_UNUSED = 3'd7;
    localparam logic [30:0] REG_TOP = 31'h7FFF_FFFF;
    localparam int EXP_DEPTH = 64;
    localparam int PLAN_DEPTH = 64;

    typedef enum int {RS_PLAIN, RS_MAX, RS_MIN, RS_ANY} reg_style_t;

    typedef struct packed {
        logic signed [31:0] lin_err;
        logic        [30:0] pass;
        logic signed [31:0] meas;
        logic        [15:0] dt;
        logic               clr;
    } tick_t;

    typedef struct packed {
        logic [31:0] sp;
        logic [31:0] drv;
    } speed_cmd_t;

    typedef struct packed {
        bit          is_cfg;
        cfg_index_t  idx;
        logic [30:0] wdata;
        tick_t       tk;
        bit          known;
        speed_cmd_t  cmd;
    } plan_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_linear_error = '0;
    logic        [30:0] s_pass_speed = '0;
    logic signed [31:0] s_measured_speed = '0;
    logic        [15:0] s_elapsed_time = '0;
    logic               s_clear_integral = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_speed_setpoint;
    logic signed [31:0] m_drive_command;
    logic               cfg_wen = 1'b0;
    cfg_index_t         cfg_index = CFG_ACCEL_MAX;
    logic        [30:0] cfg_wdata = '0;

    longint reg_accel = 65536;
    longint reg_vmax = 65536;
    longint reg_sd = 65536;
    longint reg_sdr = 65536;
    longint reg_kp = 65536;
    longint reg_ki = 0;
    longint reg_ilim = 65536;
    longint prof_last_sp = 0;
    longint prof_integral = 0;

    speed_cmd_t cmd_expect_mem[EXP_DEPTH];
    int         exp_wr = 0;
    int         exp_rd = 0;
    plan_row_t  plan_mem[PLAN_DEPTH];
    int         plan_len = 0;
    int         miss_count = 0;
    bit         src_calm = 1'b0;

    speed_profile_pi_axis_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_linear_error  (s_linear_error),
        .s_pass_speed    (s_pass_speed),
        .s_measured_speed(s_measured_speed),
        .s_elapsed_time  (s_elapsed_time),
        .s_clear_integral(s_clear_integral),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_speed_setpoint(m_speed_setpoint),
        .m_drive_command (m_drive_command),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clip32(input longint x);
        if (x > Q_MAX) return Q_MAX;
        if (x < Q_MIN) return Q_MIN;
        return x;
    endfunction

    function automatic longint q16_mul(input longint a, input longint b);
        bit neg;
        longint unsigned ma, mb, mag, lim;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mag = (ma * mb) >> 16;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (mag > lim) mag = lim;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic speed_cmd_t profile_tick(input tick_t t);
        longint err, pass, meas, dt, sp, e, ramp, drive;
        speed_cmd_t r;
        err = longint'($signed(t.lin_err));
        pass = longint'({1'b0, t.pass});
        meas = longint'($signed(t.meas));
        dt = longint'({16'd0, t.dt});
        if (err == 0) begin
            sp = 0;
        end else if (err > 0) begin
            sp = clip32(prof_last_sp + q16_mul(reg_accel, dt));
            if (sp > reg_vmax) sp = reg_vmax;
            if (err < reg_sd) begin
                ramp = clip32(pass + q16_mul(q16_mul(clip32(reg_vmax - pass), err), reg_sdr));
                if (ramp < sp) sp = ramp;
            end
        end else begin
            sp = clip32(prof_last_sp - q16_mul(reg_accel, dt));
            if (sp < -reg_vmax) sp = -reg_vmax;
            if (err > -reg_sd) begin
                ramp = clip32(-pass + q16_mul(q16_mul(clip32(reg_vmax - pass), err), reg_sdr));
                if (ramp > sp) sp = ramp;
            end
        end
        prof_last_sp = sp;
        e = clip32(sp - meas);
        if (t.clr) prof_integral = 0;
        prof_integral = clip32(prof_integral + q16_mul(e, dt));
        if (prof_integral > reg_ilim) prof_integral = reg_ilim;
        else if (prof_integral < -reg_ilim) prof_integral = -reg_ilim;
        drive = clip32(q16_mul(reg_kp, e) + q16_mul(reg_ki, prof_integral));
        r.sp = sp[31:0];
        r.drv = drive[31:0];
        return r;
    endfunction

    task automatic flag_miss(input string what, input logic [31:0] want, input logic [31:0] got);
        miss_count++;
        if (miss_count <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic drain_ticks();
        s_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [30:0] val);
        drain_ticks();
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_ACCEL_MAX:           reg_accel = longint'({1'b0, val});
            CFG_SPEED_MAX:           reg_vmax = longint'({1'b0, val});
            CFG_SLOW_DISTANCE:       reg_sd = longint'({1'b0, val});
            CFG_SLOW_DISTANCE_RECIP: reg_sdr = longint'({1'b0, val});
            CFG_PROP_GAIN:           reg_kp = longint'({1'b0, val});
            CFG_INTEG_GAIN:          reg_ki = longint'({1'b0, val});
            CFG_INTEG_LIMIT:         reg_ilim = longint'({1'b0, val});
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_tick(input tick_t t, input bit known, input speed_cmd_t known_cmd);
        int gap;
        speed_cmd_t pred;
        if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_linear_error <= t.lin_err;
        s_pass_speed <= t.pass;
        s_measured_speed <= t.meas;
        s_elapsed_time <= t.dt;
        s_clear_integral <= t.clr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = profile_tick(t);
        cmd_expect_mem[exp_wr % EXP_DEPTH] = known ? known_cmd : pred;
        exp_wr++;
    endtask

    task automatic plan_push(input logic [31:0] d, input logic [30:0] p, input logic [31:0] m,
                             input logic [15:0] dt, input logic c, input bit known,
                             input logic [31:0] sp, input logic [31:0] drv);
        plan_row_t row;
        row = '0;
        row.tk.lin_err = d;
        row.tk.pass = p;
        row.tk.meas = m;
        row.tk.dt = dt;
        row.tk.clr = c;
        row.known = known;
        row.cmd.sp = sp;
        row.cmd.drv = drv;
        plan_mem[plan_len] = row;
        plan_len++;
    endtask

    task automatic plan_reg(input cfg_index_t idx, input logic [30:0] val);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.wdata = val;
        plan_mem[plan_len] = row;
        plan_len++;
    endtask

    task automatic build_plan();
        // The first rows with a result typed in run under the register defaults.
        plan_push(32'h0000_0000, 31'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0,
                  1'b1, 32'h0000_0000, 32'h0000_0000);
        plan_push(32'h0000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0,
                  1'b1, 32'h0000_0000, 32'h7FFF_FFFF);
        plan_push(32'h0000_0000, 31'h0000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0,
                  1'b1, 32'h0000_0000, 32'h8000_0001);
        plan_push(32'h7FFF_FFFF, 31'h0000_0000, 32'h0000_FFFF, 16'hFFFF, 1'b0,
                  1'b1, 32'h0000_FFFF, 32'h0000_0000);
        plan_push(32'h7FFF_FFFF, 31'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0,
                  1'b1, 32'h0001_0000, 32'h0001_0000);
        plan_push(32'h0000_8000, 31'h0000_4000, 32'h0000_0000, 16'h1000, 1'b0, 1'b0, '0, '0);
        plan_push(32'h0000_8000, 31'h0002_0000, 32'h0000_8000, 16'h0100, 1'b0, 1'b0, '0, '0);
        plan_push(32'h0000_0001, 31'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, '0, '0);
        plan_push(32'hFFFF_FFFF, 31'h0000_0000, 32'h0000_0000, 16'h1000, 1'b0, 1'b0, '0, '0);
        plan_push(32'hFFFF_8000, 31'h0000_4000, 32'h0000_0000, 16'h8000, 1'b0, 1'b0, '0, '0);
        plan_push(32'h8000_0000, 31'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0, 1'b0, '0, '0);
        plan_push(32'h0000_0000, 31'h0000_0000, 32'h1234_5678, 16'hFFFF, 1'b1, 1'b0, '0, '0);
        plan_reg(CFG_INTEG_GAIN, 31'h0001_0000);
        plan_reg(CFG_INTEG_LIMIT, 31'h0000_8000);
        plan_push(32'h0003_0000, 31'h0000_0000, 32'hFFFC_0000, 16'hFFFF, 1'b0, 1'b0, '0, '0);
        plan_push(32'h0003_0000, 31'h0000_0000, 32'hFFFC_0000, 16'hFFFF, 1'b0, 1'b0, '0, '0);
        plan_push(32'hFFFD_0000, 31'h0000_0000, 32'h0004_0000, 16'hFFFF, 1'b0, 1'b0, '0, '0);
        plan_push(32'h0000_0000, 31'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1,
                  1'b1, 32'h0000_0000, 32'h0000_0000);
        plan_push(32'h0001_0000, 31'h0000_0000, 32'h0000_0000, 16'h8000, 1'b1, 1'b0, '0, '0);
        plan_reg(CFG_UNUSED, 31'h5A5A_A5A5);
        plan_push(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, 1'b0, '0, '0);
        plan_push(32'h8000_0000, 31'h0000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0);
    endtask

    task automatic load_regs(input reg_style_t style);
        longint sd;
        case (style)
            RS_MAX: begin
                write_reg(CFG_ACCEL_MAX, REG_TOP);
                write_reg(CFG_SPEED_MAX, REG_TOP);
                write_reg(CFG_SLOW_DISTANCE, REG_TOP);
                write_reg(CFG_SLOW_DISTANCE_RECIP, REG_TOP);
                write_reg(CFG_PROP_GAIN, REG_TOP);
                write_reg(CFG_INTEG_GAIN, REG_TOP);
                write_reg(CFG_INTEG_LIMIT, REG_TOP);
            end
            RS_MIN: begin
                write_reg(CFG_ACCEL_MAX, '0);
                write_reg(CFG_SPEED_MAX, '0);
                write_reg(CFG_SLOW_DISTANCE, 31'd1);
                write_reg(CFG_SLOW_DISTANCE_RECIP, '0);
                write_reg(CFG_PROP_GAIN, '0);
                write_reg(CFG_INTEG_GAIN, '0);
                write_reg(CFG_INTEG_LIMIT, '0);
            end
            RS_ANY: begin
                write_reg(CFG_ACCEL_MAX, 31'($urandom));
                write_reg(CFG_SPEED_MAX, 31'($urandom));
                write_reg(CFG_SLOW_DISTANCE, 31'($urandom_range(1, 32'h7FFF_FFFF)));
                write_reg(CFG_SLOW_DISTANCE_RECIP, 31'($urandom));
                write_reg(CFG_PROP_GAIN, 31'($urandom));
                write_reg(CFG_INTEG_GAIN, 31'($urandom));
                write_reg(CFG_INTEG_LIMIT, 31'($urandom));
            end
            default: begin
                sd = longint'($urandom_range(32'h1000, 32'h4_0000));
                write_reg(CFG_ACCEL_MAX, 31'($urandom_range(32'h800, 32'h4_0000)));
                write_reg(CFG_SPEED_MAX, 31'($urandom_range(32'h1000, 32'h4_0000)));
                write_reg(CFG_SLOW_DISTANCE, 31'(sd));
                write_reg(CFG_SLOW_DISTANCE_RECIP, 31'((64'd1 << 32) / sd));
                write_reg(CFG_PROP_GAIN, 31'($urandom_range(0, 32'h4_0000)));
                write_reg(CFG_INTEG_GAIN, 31'($urandom_range(0, 32'h4_0000)));
                write_reg(CFG_INTEG_LIMIT, 31'($urandom_range(0, 32'h2_0000)));
            end
        endcase
        write_reg(CFG_UNUSED, 31'($urandom));
    endtask

    function automatic tick_t noise_tick();
        tick_t t;
        t.lin_err = $urandom;
        t.pass = 31'($urandom);
        t.meas = $urandom;
        t.dt = 16'($urandom);
        t.clr = 1'($urandom);
        return t;
    endfunction

    // Each move approaches a target over a few ticks with the measured speed
    // trailing the setpoint; a few ticks are replaced by noise or a jump.
    task automatic run_moves(input int n_items);
        int sent, steps, k;
        longint d0, d, pass;
        bit neg;
        tick_t t;
        sent = 0;
        while (sent < n_items) begin
            steps = $urandom_range(3, 24);
            if ($urandom_range(0, 3) == 0) d0 = longint'($urandom_range(1, 32'h7FFF_FFFF));
            else d0 = longint'($urandom_range(1, 32'h6_0000));
            neg = 1'($urandom);
            pass = (reg_vmax * longint'($urandom_range(0, 6))) / 4;
            if (pass > Q_MAX) pass = Q_MAX;
            for (k = 0; k < steps && sent < n_items; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    t = noise_tick();
                end else begin
                    d = d0 - (d0 * k) / (steps - 1);
                    if ($urandom_range(0, 31) == 0) d = longint'($urandom_range(0, 32'h7FFF_FFFF));
                    if (k == steps - 1 && $urandom_range(0, 3) == 0)
                        d = -longint'($urandom_range(0, 32'h8000));
                    t.lin_err = neg ? 32'(-d) : 32'(d);
                    t.pass = 31'(pass);
                    t.meas = 32'(clip32(prof_last_sp + longint'($urandom_range(0, 32'h4000))
                                        - 64'sd8192));
                    if ($urandom_range(0, 7) == 0) t.dt = 16'($urandom);
                    else t.dt = 16'($urandom_range(0, 4000));
                    t.clr = (k == 0) || ($urandom_range(0, 31) == 0);
                end
                send_tick(t, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin : beat_sink
        int stall;
        bit calm;
        speed_cmd_t want;
        calm = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (exp_wr == exp_rd) begin
                flag_miss("beat with no tick pending", 'x, m_speed_setpoint);
            end else begin
                want = cmd_expect_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_speed_setpoint !== want.sp)
                    flag_miss("speed_setpoint", want.sp, m_speed_setpoint);
                if (m_drive_command !== want.drv)
                    flag_miss("drive_command", want.drv, m_drive_command);
            end
        end
    end

    initial begin : stimulus
        plan_row_t row;
        reg_style_t styles[8];
        int n;
        styles = '{RS_PLAIN, RS_MAX, RS_PLAIN, RS_MIN, RS_ANY, RS_PLAIN, RS_ANY, RS_PLAIN};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        build_plan();
        for (n = 0; n < plan_len; n++) begin
            row = plan_mem[n];
            if (row.is_cfg) write_reg(row.idx, row.wdata);
            else send_tick(row.tk, row.known, row.cmd);
        end
        foreach (styles[i]) begin
            load_regs(styles[i]);
            run_moves(220);
        end
        drain_ticks();
        repeat (TICK_CYCLES) @(posedge aclk);
        if (miss_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
